[rtl/ipv4pc_pkg.sv]
package ipv4pc_pkg;

  // Character codes
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;

  localparam int unsigned PortWidth = 17;
  localparam logic [PortWidth-1:0] PortMax = 17'd65535;
  localparam logic [PortWidth-1:0] PortSat = 17'd65536;
  localparam logic [1:0] GroupDigits = 2'd3;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PhGroup0  = 7'b0000001,
    PhGroup1  = 7'b0000010,
    PhGroup2  = 7'b0000100,
    PhGroup3  = 7'b0001000,
    PhPortPre = 7'b0010000,
    PhPortDig = 7'b0100000,
    PhPortEnd = 7'b1000000
  } phase_e;

  // Result of one item
  typedef struct packed {
    logic verdict_ready;
    logic text_valid;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

[rtl/ipv4_with_port_text_checker_core.sv]
// Streaming checker for text of the form a.b.c.d:port, one byte per item,
// terminated by a zero byte. Every input item produces one result item;
// verdict_ready_o is set on the result of the terminator, and text_valid_o
// then tells whether the whole text was a valid address with port (it is 0
// on all other results). Items enter an input register and are parsed
// combinationally into an output register, so one item is accepted per
// clock while out_ready_i allows it; a stalled result register holds the
// input register. The parser state update sets the rate. After each
// terminator the parser starts over on a new text.
module ipv4_with_port_text_checker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       verdict_ready_o,
  output logic       text_valid_o
);

  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                out_valid_q;
  ipv4pc_pkg::result_t result_q;
  ipv4pc_pkg::result_t step_result;
  logic                step;

  // Process the held item when the result register is free
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  ipv4pc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_code_i (char_q),
    .result_o    (step_result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_ready_o = result_q.verdict_ready;
  assign text_valid_o    = result_q.text_valid;

endmodule

[rtl/ipv4pc_parser.sv]
module ipv4pc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_code_i,
  output ipv4pc_pkg::result_t  result_o
);

  ipv4pc_pkg::phase_e phase_q, phase_d;
  logic [1:0]  digits_left_q, digits_left_d;
  logic        rejected_q, rejected_d;
  logic        port_negative_q, port_negative_d;
  logic [ipv4pc_pkg::PortWidth-1:0] port_value_q, port_value_d;

  logic        is_term;
  logic        is_dig;
  logic [7:0]  sep_char;
  logic [3:0]  digit_val;
  logic [19:0] port_times_ten;
  logic [19:0] port_acc;
  logic [ipv4pc_pkg::PortWidth-1:0] port_next;
  logic        in_group;

  assign is_term   = (char_code_i == ipv4pc_pkg::CharNul);
  assign is_dig    = ipv4pc_pkg::is_digit(char_code_i);
  assign digit_val = 4'(char_code_i - ipv4pc_pkg::CharZero);
  assign sep_char  = (phase_q == ipv4pc_pkg::PhGroup3) ? ipv4pc_pkg::CharColon
                                                        : ipv4pc_pkg::CharDot;
  assign in_group  = (phase_q == ipv4pc_pkg::PhGroup0) || (phase_q == ipv4pc_pkg::PhGroup1) ||
                     (phase_q == ipv4pc_pkg::PhGroup2) || (phase_q == ipv4pc_pkg::PhGroup3);

  // Accumulate port digit: value * 10 + digit, saturate above the max
  assign port_times_ten = {port_value_q, 3'b000} + {2'b00, port_value_q, 1'b0};
  assign port_acc       = port_times_ten + {16'd0, digit_val};
  assign port_next      = (port_acc > {3'b000, ipv4pc_pkg::PortMax}) ? ipv4pc_pkg::PortSat
                                                                    : port_acc[16:0];

  // Verdict on the terminator
  always_comb begin
    result_o.verdict_ready = is_term;
    result_o.text_valid    = is_term && !rejected_q && !in_group &&
                             (port_value_q <= ipv4pc_pkg::PortMax) &&
                             (!port_negative_q || (port_value_q == '0));
  end

  // Advance the parser state
  always_comb begin
    phase_d         = phase_q;
    digits_left_d   = digits_left_q;
    rejected_d      = rejected_q;
    port_negative_d = port_negative_q;
    port_value_d    = port_value_q;
    if (is_term) begin
      phase_d         = ipv4pc_pkg::PhGroup0;
      digits_left_d   = ipv4pc_pkg::GroupDigits;
      rejected_d      = 1'b0;
      port_negative_d = 1'b0;
      port_value_d    = '0;
    end else if (!rejected_q) begin
      unique case (phase_q)
        ipv4pc_pkg::PhGroup0, ipv4pc_pkg::PhGroup1,
        ipv4pc_pkg::PhGroup2, ipv4pc_pkg::PhGroup3: begin
          if (char_code_i == sep_char) begin
            phase_d       = ipv4pc_pkg::phase_e'({phase_q[5:0], 1'b0});
            digits_left_d = ipv4pc_pkg::GroupDigits;
          end else if (is_dig && (digits_left_q != 2'd0)) begin
            digits_left_d = digits_left_q - 2'd1;
          end else begin
            rejected_d = 1'b1;
          end
        end
        ipv4pc_pkg::PhPortPre: begin
          priority if (ipv4pc_pkg::is_space(char_code_i)) begin
            phase_d = ipv4pc_pkg::PhPortPre;
          end else if (char_code_i == ipv4pc_pkg::CharPlus) begin
            phase_d = ipv4pc_pkg::PhPortDig;
          end else if (char_code_i == ipv4pc_pkg::CharMinus) begin
            port_negative_d = 1'b1;
            phase_d         = ipv4pc_pkg::PhPortDig;
          end else if (is_dig) begin
            port_value_d = port_next;
            phase_d      = ipv4pc_pkg::PhPortDig;
          end else begin
            phase_d = ipv4pc_pkg::PhPortEnd;
          end
        end
        ipv4pc_pkg::PhPortDig: begin
          if (is_dig) begin
            port_value_d = port_next;
          end else begin
            phase_d = ipv4pc_pkg::PhPortEnd;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Hold state unless an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= ipv4pc_pkg::PhGroup0;
      digits_left_q   <= ipv4pc_pkg::GroupDigits;
      rejected_q      <= 1'b0;
      port_negative_q <= 1'b0;
      port_value_q    <= '0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      digits_left_q   <= digits_left_d;
      rejected_q      <= rejected_d;
      port_negative_q <= port_negative_d;
      port_value_q    <= port_value_d;
    end
  end

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_term |=> (phase_q == ipv4pc_pkg::PhGroup0) && !rejected_q &&
                          (port_value_q == '0) && !port_negative_q)
    else $error("parser did not restart after terminator");

  a_port_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_value_q <= ipv4pc_pkg::PortSat)
    else $error("port value above saturation");

  a_reject_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rejected_q |-> in_group)
    else $error("rejection outside address groups");

  a_sign_in_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_negative_q |-> (phase_q == ipv4pc_pkg::PhPortDig) ||
                        (phase_q == ipv4pc_pkg::PhPortEnd))
    else $error("sign flag set before port digits");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

endmodule

[sim/text_verdict_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the address-with-port text checker, works out
// the verdict of every accepted character and compares it with what leaves
// the block.
module text_verdict_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_code_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       verdict_ready_i,
  input  logic       text_valid_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         texts_o,
  output int         accepted_o
);

  // Parser state as the block should hold it
  ipv4pc_pkg::phase_e               phase;
  logic [1:0]                       digits_left;
  logic                             rejected;
  logic                             port_neg;
  logic [ipv4pc_pkg::PortWidth-1:0] port_val;

  // Results still owed by the block, oldest first
  ipv4pc_pkg::result_t verdict_q[$];

  int fails = 0;
  int texts = 0;
  int accepted = 0;
  int pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign texts_o      = texts;
  assign accepted_o   = accepted;

  function automatic logic numeral(input logic [7:0] c);
    return (c >= ipv4pc_pkg::CharZero) && (c <= ipv4pc_pkg::CharNine);
  endfunction

  // Space plus the control range tab .. carriage return
  function automatic logic blank(input logic [7:0] c);
    return (c == ipv4pc_pkg::CharSpace) ||
           ((c >= ipv4pc_pkg::CharTab) && (c <= ipv4pc_pkg::CharCr));
  endfunction

  function automatic void clear_parse();
    phase       = ipv4pc_pkg::PhGroup0;
    digits_left = ipv4pc_pkg::GroupDigits;
    rejected    = 1'b0;
    port_neg    = 1'b0;
    port_val    = '0;
  endfunction

  // Accumulate one port digit, saturating just past the largest port
  function automatic void take_port_digit(input logic [7:0] c);
    int unsigned sum;
    sum = port_val * 10 + (c - ipv4pc_pkg::CharZero);
    port_val = (sum > ipv4pc_pkg::PortMax) ? ipv4pc_pkg::PortSat
                                           : sum[ipv4pc_pkg::PortWidth-1:0];
  endfunction

  // Advance the parser by one character and return the result it owes
  function automatic ipv4pc_pkg::result_t parse_char(input logic [7:0] c);
    ipv4pc_pkg::result_t res;
    logic [7:0] sep;
    res = '0;
    if (c == ipv4pc_pkg::CharNul) begin
      res.verdict_ready = 1'b1;
      res.text_valid = !rejected &&
                       (phase == ipv4pc_pkg::PhPortPre || phase == ipv4pc_pkg::PhPortDig ||
                        phase == ipv4pc_pkg::PhPortEnd) &&
                       (port_val <= ipv4pc_pkg::PortMax) && (!port_neg || port_val == '0);
      clear_parse();
      return res;
    end
    if (rejected) return res;
    case (phase)
      ipv4pc_pkg::PhGroup0, ipv4pc_pkg::PhGroup1,
      ipv4pc_pkg::PhGroup2, ipv4pc_pkg::PhGroup3: begin
        sep = (phase == ipv4pc_pkg::PhGroup3) ? ipv4pc_pkg::CharColon : ipv4pc_pkg::CharDot;
        if (c == sep) begin
          case (phase)
            ipv4pc_pkg::PhGroup0: phase = ipv4pc_pkg::PhGroup1;
            ipv4pc_pkg::PhGroup1: phase = ipv4pc_pkg::PhGroup2;
            ipv4pc_pkg::PhGroup2: phase = ipv4pc_pkg::PhGroup3;
            default:              phase = ipv4pc_pkg::PhPortPre;
          endcase
          digits_left = ipv4pc_pkg::GroupDigits;
        end else if (numeral(c) && digits_left != 2'd0) begin
          digits_left = digits_left - 2'd1;
        end else begin
          rejected = 1'b1;
        end
      end
      ipv4pc_pkg::PhPortPre: begin
        if (blank(c)) begin
          // hold in the preamble
        end else if (c == ipv4pc_pkg::CharPlus) begin
          phase = ipv4pc_pkg::PhPortDig;
        end else if (c == ipv4pc_pkg::CharMinus) begin
          port_neg = 1'b1;
          phase = ipv4pc_pkg::PhPortDig;
        end else if (numeral(c)) begin
          take_port_digit(c);
          phase = ipv4pc_pkg::PhPortDig;
        end else begin
          phase = ipv4pc_pkg::PhPortEnd;
        end
      end
      ipv4pc_pkg::PhPortDig: begin
        if (numeral(c)) take_port_digit(c);
        else phase = ipv4pc_pkg::PhPortEnd;
      end
      default: begin
        // drop everything after the port
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("%0t ns checker: %s, got %0b want %0b", $time, what, got, want);
    fails++;
  endtask

  // Predict on accepted characters, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    ipv4pc_pkg::result_t want;
    if (!rst_ni) begin
      clear_parse();
      verdict_q.delete();
      pending = 0;
    end else begin
      if (in_valid_i && in_ready_i) verdict_q.push_back(parse_char(char_code_i));
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing expected", verdict_ready_i, 1'b0);
        end else begin
          want = verdict_q.pop_front();
          if (verdict_ready_i !== want.verdict_ready)
            report_mismatch("verdict_ready", verdict_ready_i, want.verdict_ready);
          if (text_valid_i !== want.text_valid)
            report_mismatch("text_valid", text_valid_i, want.text_valid);
          if (want.verdict_ready) begin
            texts++;
            if (want.text_valid) accepted++;
          end
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int TotalChars     = 650;
  localparam int CalmAfter      = 560;
  localparam int PressureAt     = 150;
  localparam int PressureCycles = 80;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       verdict_ready_o;
  logic       text_valid_o;

  int fail_count;
  int pending;
  int texts;
  int accepted;

  int sent_chars = 0;
  bit pressure_done = 1'b0;

  // Text under construction, terminator included
  logic [7:0] text_q[$];

  ipv4_with_port_text_checker_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_ready_o (verdict_ready_o),
    .text_valid_o    (text_valid_o)
  );

  text_verdict_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .char_code_i     (char_code_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_ready_i (verdict_ready_o),
    .text_valid_i    (text_valid_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .texts_o         (texts),
    .accepted_o      (accepted)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one character, with an occasional idle burst in front of it
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (sent_chars < CalmAfter && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_chars++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    text_q.delete();
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    text_q.push_back(ipv4pc_pkg::CharNul);
  endtask

  task automatic add_digits(input int n);
    repeat (n) text_q.push_back(8'(ipv4pc_pkg::CharZero + $urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 2) == 0) return ipv4pc_pkg::CharSpace;
    return 8'($urandom_range(ipv4pc_pkg::CharTab, ipv4pc_pkg::CharCr));
  endfunction

  // Well-formed address with a random port part, now and then too many digits
  task automatic build_address();
    int n;
    int port_kind;
    for (int g = 0; g < 4; g++) begin
      n = ($urandom_range(0, 19) == 0) ? 4 : $urandom_range(0, 3);
      add_digits(n);
      text_q.push_back((g == 3) ? ipv4pc_pkg::CharColon : ipv4pc_pkg::CharDot);
    end
    repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
    case ($urandom_range(0, 5))
      4: text_q.push_back(ipv4pc_pkg::CharPlus);
      5: text_q.push_back(ipv4pc_pkg::CharMinus);
      default: ;
    endcase
    port_kind = $urandom_range(0, 5);
    case (port_kind)
      0: ;
      1: begin
        // straddle the largest port
        text_q.push_back(8'(ipv4pc_pkg::CharZero + 6));
        text_q.push_back(8'(ipv4pc_pkg::CharZero + 5));
        text_q.push_back(8'(ipv4pc_pkg::CharZero + 5));
        text_q.push_back(8'(ipv4pc_pkg::CharZero + 3));
        text_q.push_back(8'(ipv4pc_pkg::CharZero + $urandom_range(5, 6)));
      end
      2: add_digits($urandom_range(5, 7));
      default: add_digits($urandom_range(1, 4));
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
    text_q.push_back(ipv4pc_pkg::CharNul);
  endtask

  // Corrupt one character, or end the text early
  task automatic build_broken();
    int idx;
    build_address();
    idx = $urandom_range(0, text_q.size() - 2);
    if ($urandom_range(0, 1) == 0) begin
      text_q[idx] = 8'($urandom_range(1, 255));
    end else begin
      while (text_q.size() > idx) void'(text_q.pop_back());
      text_q.push_back(ipv4pc_pkg::CharNul);
    end
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(1, 255)));
    text_q.push_back(ipv4pc_pkg::CharNul);
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!pressure_done && sent_chars >= PressureAt) begin
        out_ready_i <= 1'b0;
        repeat (PressureCycles) @(posedge clk_i);
        pressure_done = 1'b1;
      end else if (sent_chars < CalmAfter && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty text, negative zero port, empty port, long group, bad char, overflow
    text_q.push_back(ipv4pc_pkg::CharNul);
    send_text();
    append_str("...:-0");
    send_text();
    append_str("...:");
    send_text();
    append_str("1234");
    send_text();
    append_str("x");
    send_text();
    append_str("...:65536");
    send_text();

    while (sent_chars < TotalChars) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) build_address();
      else if (pick < 9) build_broken();
      else build_noise();
      send_text();
    end
    in_valid_i <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d characters in %0d texts, %0d judged valid, %0d invalid",
             sent_chars, texts, accepted, texts - accepted);
    $display("summary: random stalls on both sides plus one %0d-cycle output hold-off",
             PressureCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/ipv4pc_pkg.sv
rtl/ipv4pc_parser.sv
rtl/ipv4_with_port_text_checker_core.sv
sim/text_verdict_checker.sv
sim/tb_top.sv
